// File: hdl/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and codes for the box pair overlap event core
// command, event and status codes used by the core and its datapath
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam logic [1:0] CMD_REGISTER = 2'd0;
  localparam logic [1:0] CMD_MOVE     = 2'd1;
  localparam logic [1:0] CMD_TICK     = 2'd2;

  localparam logic [1:0] EV_ENTER = 2'd0;
  localparam logic [1:0] EV_STAY  = 2'd1;
  localparam logic [1:0] EV_EXIT  = 2'd2;
  localparam logic [1:0] EV_ACK   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] first_box;
    logic [2:0] second_box;
    logic [1:0] status;
    logic       last;
  } result_t;

endpackage

// File: hdl/aabb_pair_collision_events_core.sv
// ----------------------------------------------------------------------------
// aabb_pair_collision_events_core: broad-phase box pair overlap tracker
// keeps up to MAX_BOXES boxes and reports enter, stay and exit per pair
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one command beat: register, move or tick (tuser = cmd)
//   m_axis carries result beats; tlast marks the final beat of a command
//   register and move give one acknowledgement beat in the cycle after
//   acceptance; a tick sweeps pairs (0,k)..(k-1,k)
// flow:
//   one command at a time; a tick visits the pairs of stored boxes in turn,
//   up to 28 at the default size, each through the box memory read, the
//   overlap register and the flag update
// the box store has two registered read ports, the pair flags are a
//   register vector cleared by reset
// each event beat is held back one pair so tlast can mark the final one
// reset clears the box count, the pair flags and the control state
// when the receiver stalls the output register holds and the sweep waits
// ----------------------------------------------------------------------------
module aabb_pair_collision_events_core
  import aabb_pkg::*;
#(
  parameter int MAX_BOXES   = 8,
  parameter int COORD_WIDTH = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // box_slot[2:0], center_x, center_y, center_z, extent_x, extent_y, extent_z,
  // which fill all 192 bits
  input  logic [191:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // event_kind[1:0], first_box[4:2], second_box[7:5], status[9:8], zero fill
  output logic [15:0]  m_axis_tdata,
  output logic         m_axis_tlast
);

  localparam int CW    = COORD_WIDTH;
  localparam int EW    = CW - 1;
  localparam int AW    = $clog2(MAX_BOXES);
  localparam int NW    = $clog2(MAX_BOXES + 1);
  localparam int PAIRS = MAX_BOXES * (MAX_BOXES - 1) / 2;
  localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int DW    = 3 * CW + 3 * EW;
  localparam int KC    = (CW < 32) ? CW : 32;
  localparam int KE    = (EW < 31) ? EW : 31;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_TEST, S_EVAL, S_DONE
  } state_t;

  state_t         state;
  logic [NW-1:0]  box_count;
  logic [AW-1:0]  idx_i, idx_k;
  logic [PW-1:0]  pair;
  logic           any_event;
  logic [PAIRS-1:0] flags;
  result_t        res;
  result_t        held;
  result_t        ack_res;
  logic           out_valid;

  // input unpacking, narrowed or widened to the stored width
  logic [2:0]    in_slot;
  logic [DW-1:0] in_box;
  always_comb begin
    in_slot = s_axis_tdata[2:0];
    in_box  = '0;
    for (int ax = 0; ax < 3; ax++) begin
      logic [31:0] c;
      logic [30:0] e;
      c = s_axis_tdata[3 + ax*32 +: 32];
      e = s_axis_tdata[99 + ax*31 +: 31];
      for (int b = 0; b < CW; b++) begin
        in_box[ax*CW + b] = (b < KC) ? c[(b < KC) ? b : KC-1] : c[KC-1];
      end
      for (int b = 0; b < EW; b++) begin
        in_box[3*CW + ax*EW + b] = (b < KE) ? e[(b < KE) ? b : 0] : 1'b0;
      end
    end
  end

  // box memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] rd_a, rd_b;
  logic          ovl;

  aabb_box_mem #(.DEPTH(MAX_BOXES), .AW(AW), .DW(DW)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (in_box),
    .raddr_a (idx_i),
    .raddr_b (idx_k),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  aabb_overlap #(.CW(CW)) u_ovl (
    .clk       (clk),
    .centers_a (rd_a[3*CW-1:0]),
    .centers_b (rd_b[3*CW-1:0]),
    .sizes_a   (rd_a[DW-1:3*CW]),
    .sizes_b   (rd_b[DW-1:3*CW]),
    .overlap   (ovl)
  );

  logic accept_in;
  assign s_axis_tready = (state == S_IDLE) && !out_valid;
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign mem_we        = accept_in && (
                           (s_axis_tuser == CMD_REGISTER && box_count < NW'(MAX_BOXES)) ||
                           (s_axis_tuser == CMD_MOVE && {1'b0, in_slot} < 4'(box_count)));
  assign mem_waddr     = (s_axis_tuser == CMD_REGISTER) ? AW'(box_count) : AW'(in_slot);

  // acknowledgement beat for register, move, short tick and unused commands
  always_comb begin
    ack_res = '{kind: EV_ACK, first_box: 3'd0, second_box: 3'd0,
                status: ST_OK, last: 1'b1};
    case (s_axis_tuser)
      CMD_REGISTER: begin
        if (box_count >= NW'(MAX_BOXES)) ack_res.status = ST_FULL;
        else ack_res.first_box = 3'(box_count);
      end
      CMD_MOVE: begin
        ack_res.first_box = in_slot;
        if ({1'b0, in_slot} >= 4'(box_count)) ack_res.status = ST_BAD_SLOT;
      end
      default: ;
    endcase
  end

  logic was;
  assign was = flags[pair];
  logic last_pair;
  assign last_pair = (NW'(idx_k) + NW'(1) >= box_count) && (idx_i + AW'(1) == idx_k);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      box_count <= '0;
      flags     <= '0;
      out_valid <= 1'b0;
      idx_i     <= '0;
      idx_k     <= '0;
      pair      <= '0;
      any_event <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept_in) begin
            res <= ack_res;
            case (s_axis_tuser)
              CMD_REGISTER: begin
                if (box_count < NW'(MAX_BOXES)) box_count <= box_count + NW'(1);
                out_valid <= 1'b1;
              end
              CMD_TICK: begin
                any_event <= 1'b0;
                pair      <= '0;
                idx_i     <= '0;
                idx_k     <= AW'(1);
                if (box_count < NW'(2)) out_valid <= 1'b1;
                else state <= S_READ;
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        S_READ: state <= S_TEST;
        S_TEST: state <= S_EVAL;
        S_EVAL: begin
          // the overlap result stays put while waiting for the output slot
          if (!out_valid) begin
            flags[pair] <= ovl;
            if (ovl || was) begin
              if (any_event) begin
                res       <= held;
                out_valid <= 1'b1;
              end
              held <= '{kind: ovl ? (was ? EV_STAY : EV_ENTER) : EV_EXIT,
                        first_box: 3'(idx_i), second_box: 3'(idx_k),
                        status: ST_OK, last: 1'b0};
              any_event <= 1'b1;
            end
            if (last_pair) begin
              state <= S_DONE;
            end else begin
              pair <= pair + PW'(1);
              if (idx_i + AW'(1) == idx_k) begin
                idx_i <= '0;
                idx_k <= idx_k + AW'(1);
              end else begin
                idx_i <= idx_i + AW'(1);
              end
              state <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (!out_valid) begin
            if (!any_event) begin
              res <= '{kind: EV_ACK, first_box: 3'd0, second_box: 3'd0,
                       status: ST_OK, last: 1'b1};
            end else begin
              res <= '{kind: held.kind, first_box: held.first_box,
                       second_box: held.second_box, status: held.status,
                       last: 1'b1};
            end
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = res.last;
  assign m_axis_tdata  = {6'd0, res.status, res.second_box, res.first_box, res.kind};

endmodule

// File: hdl/aabb_box_mem.sv
// ----------------------------------------------------------------------------
// aabb_box_mem: box store, one write port and two registered read ports
// each entry holds three centers and three full sizes
// ----------------------------------------------------------------------------
module aabb_box_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3,
  parameter int DW    = 189
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// File: hdl/aabb_overlap.sv
// ----------------------------------------------------------------------------
// aabb_overlap: per-axis overlap test, registered result
// overlap when 2*|ca-cb| <= sa+sb on all three axes
// ----------------------------------------------------------------------------
module aabb_overlap #(
  parameter int CW = 32
) (
  input  logic                 clk,
  input  logic [3*CW-1:0]      centers_a,
  input  logic [3*CW-1:0]      centers_b,
  input  logic [3*(CW-1)-1:0]  sizes_a,
  input  logic [3*(CW-1)-1:0]  sizes_b,
  output logic                 overlap
);

  logic [2:0] axis_ok;

  always_comb begin
    logic signed [CW:0] d;
    logic [CW:0]        ad;
    logic [CW+1:0]      lhs;
    logic [CW:0]        rhs;
    for (int ax = 0; ax < 3; ax++) begin
      d   = $signed({centers_a[ax*CW+CW-1], centers_a[ax*CW +: CW]})
          - $signed({centers_b[ax*CW+CW-1], centers_b[ax*CW +: CW]});
      ad  = d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
      lhs = {ad, 1'b0};
      rhs = {2'b00, sizes_a[ax*(CW-1) +: CW-1]} + {2'b00, sizes_b[ax*(CW-1) +: CW-1]};
      axis_ok[ax] = lhs <= {1'b0, rhs};
    end
  end

  always_ff @(posedge clk) begin
    overlap <= &axis_ok;
  end

endmodule

// File: verif/aabb_pair_collision_events_core_test.sv
// ----------------------------------------------------------------------------
// aabb_pair_collision_events_core_test: self-checking bench for the pair core
// drives register, move and tick commands and predicts every result beat
// from its own model of the box table and pair flags, under random idling
// ----------------------------------------------------------------------------
module aabb_pair_collision_events_core_test
  import aabb_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_BOXES   = 8;
  localparam int NUM_PAIRS   = NUM_BOXES * (NUM_BOXES - 1) / 2;
  localparam int CYCLE_LIMIT = 1000000;

  logic         clk;
  logic         rst;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [191:0] s_axis_tdata;
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [15:0]  m_axis_tdata;
  logic         m_axis_tlast;

  // predicted box table and pair flags
  int                 boxes_held;
  logic signed [31:0] box_center [NUM_BOXES][3];
  logic [30:0]        box_extent [NUM_BOXES][3];
  logic               pair_touching [NUM_PAIRS];

  result_t pending_results[$];
  int      mismatches = 0;
  int      cycle_count = 0;
  int      send_idle_pct;
  int      recv_stall_pct;
  int      hold_until;

  aabb_pair_collision_events_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("aabb_pair_collision_events_core regression: fail");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off when a test asks for one
  always @(posedge clk) begin
    if (cycle_count < hold_until)
      m_axis_tready <= 1'b0;
    else
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // result checker: one beat against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data %h", m_axis_tdata));
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] != want.kind)
          report_mismatch($sformatf("kind %0d want %0d", m_axis_tdata[1:0], want.kind));
        if (m_axis_tdata[4:2] != want.first_box)
          report_mismatch($sformatf("first_box %0d want %0d",
                                    m_axis_tdata[4:2], want.first_box));
        if (m_axis_tdata[7:5] != want.second_box)
          report_mismatch($sformatf("second_box %0d want %0d",
                                    m_axis_tdata[7:5], want.second_box));
        if (m_axis_tdata[9:8] != want.status)
          report_mismatch($sformatf("status %0d want %0d", m_axis_tdata[9:8], want.status));
        if (m_axis_tlast != want.last)
          report_mismatch($sformatf("tlast %0b want %0b", m_axis_tlast, want.last));
      end
    end
  end

  function automatic void push_result(input logic [1:0] kind, input int a, input int b,
                                      input logic [1:0] status);
    result_t r;
    r.kind       = kind;
    r.first_box  = a[2:0];
    r.second_box = b[2:0];
    r.status     = status;
    r.last       = 1'b0;
    pending_results = {pending_results, r};
  endfunction

  function automatic bit boxes_touch(input int a, input int b);
    longint gap;
    longint reach;
    for (int ax = 0; ax < 3; ax++) begin
      gap = longint'(box_center[a][ax]) - longint'(box_center[b][ax]);
      if (gap < 0)
        gap = -gap;
      reach = longint'({1'b0, box_extent[a][ax]}) + longint'({1'b0, box_extent[b][ax]});
      if (2 * gap > reach)
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void store_box(input int slot, input logic [191:0] d);
    box_center[slot][0] = d[34:3];
    box_center[slot][1] = d[66:35];
    box_center[slot][2] = d[98:67];
    box_extent[slot][0] = d[129:99];
    box_extent[slot][1] = d[160:130];
    box_extent[slot][2] = d[191:161];
  endfunction

  // expected result beats of one accepted command
  function automatic void predict_command(input logic [1:0] cmd, input logic [191:0] d);
    int  slot;
    int  p;
    int  queued_prior;
    bit  now;
    result_t r;
    slot         = int'(d[2:0]);
    queued_prior = pending_results.size();
    case (cmd)
      CMD_REGISTER: begin
        if (boxes_held >= NUM_BOXES) begin
          push_result(EV_ACK, 0, 0, ST_FULL);
        end else begin
          store_box(boxes_held, d);
          push_result(EV_ACK, boxes_held, 0, ST_OK);
          boxes_held++;
        end
      end
      CMD_MOVE: begin
        if (slot >= boxes_held) begin
          push_result(EV_ACK, slot, 0, ST_BAD_SLOT);
        end else begin
          store_box(slot, d);
          push_result(EV_ACK, slot, 0, ST_OK);
        end
      end
      CMD_TICK: begin
        p = 0;
        for (int k = 1; k < boxes_held; k++) begin
          for (int i = 0; i < k; i++) begin
            now = boxes_touch(i, k);
            if (now && !pair_touching[p])
              push_result(EV_ENTER, i, k, ST_OK);
            else if (now)
              push_result(EV_STAY, i, k, ST_OK);
            else if (pair_touching[p])
              push_result(EV_EXIT, i, k, ST_OK);
            pair_touching[p] = now;
            p++;
          end
        end
        if (pending_results.size() == queued_prior)
          push_result(EV_ACK, 0, 0, ST_OK);
      end
      default: push_result(EV_ACK, 0, 0, ST_OK);
    endcase
    r = pending_results[$];
    r.last = 1'b1;
    pending_results[$] = r;
  endfunction

  // one command beat; tvalid stays high into the next call unless it idles
  task automatic send_command(input logic [1:0] cmd, input logic [191:0] d);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do
        @(posedge clk);
      while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= cmd;
    do
      @(posedge clk);
    while (!s_axis_tready);
    predict_command(cmd, d);
  endtask

  // extents use the low 31 bits of their arguments
  function automatic logic [191:0] box_beat(input int slot,
      input logic [31:0] cx, input logic [31:0] cy, input logic [31:0] cz,
      input logic [31:0] ex, input logic [31:0] ey, input logic [31:0] ez);
    logic [2:0] s;
    s = slot[2:0];
    return {ez[30:0], ey[30:0], ex[30:0], cz, cy, cx, s};
  endfunction

  function automatic logic [31:0] rand_center();
    if ($urandom_range(99) < 75)
      return $urandom_range(32'h0004_0000) - 32'h0002_0000;
    return $urandom;
  endfunction

  function automatic logic [31:0] rand_extent();
    if ($urandom_range(99) < 75)
      return $urandom_range(32'h0004_0000);
    return $urandom & 32'h7fff_ffff;
  endfunction

  function automatic logic [191:0] rand_box(input int slot);
    return box_beat(slot, rand_center(), rand_center(), rand_center(),
                    rand_extent(), rand_extent(), rand_extent());
  endfunction

  // wait for every predicted beat, then for any sweep still running
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // corner cases: empty table, bad slot, extremes, touching faces, full table
  task automatic test_directed();
    send_command(CMD_TICK, '0);
    send_command(CMD_MOVE, box_beat(7, 0, 0, 0, 0, 0, 0));
    send_command(CMD_REGISTER, box_beat(5, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_command(CMD_REGISTER, box_beat(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_command(CMD_TICK, '0);
    send_command(CMD_MOVE, box_beat(2, 0, 0, 0, 0, 0, 0));
    // same center as box 0: enter, then stay
    send_command(CMD_REGISTER, box_beat(0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                 0, 0, 0));
    send_command(CMD_TICK, '0);
    send_command(CMD_TICK, '0);
    // faces exactly touching, then half a unit apart
    send_command(CMD_MOVE, box_beat(0, 0, 0, 0, 10, 10, 10));
    send_command(CMD_MOVE, box_beat(2, 10, 0, 0, 10, 10, 10));
    send_command(CMD_TICK, '0);
    send_command(CMD_MOVE, box_beat(2, 10, 0, 0, 9, 10, 10));
    send_command(CMD_TICK, '0);
    // fill the table with boxes that all overlap
    for (int n = 3; n < NUM_BOXES; n++)
      send_command(CMD_REGISTER, box_beat(0, n, -n, 0, 100, 100, 100));
    send_command(CMD_REGISTER, box_beat(0, 0, 0, 0, 1, 1, 1));
    for (int n = 0; n < 3; n++)
      send_command(CMD_MOVE, box_beat(n, 0, 0, 0, 100, 100, 100));
    send_command(CMD_TICK, '0);
    send_command(CMD_TICK, '0);
    drain();
  endtask

  task automatic test_random(input int items, input int idle_pct, input int stall_pct);
    int pick;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 10)
        send_command(CMD_REGISTER, rand_box($urandom_range(7)));
      else if (pick < 55)
        send_command(CMD_MOVE, rand_box($urandom_range(7)));
      else
        send_command(CMD_TICK, {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    end
    drain();
  endtask

  // receiver holds off while full sweeps keep coming, so the core backs up
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_until = cycle_count + 400;
    for (int n = 0; n < NUM_BOXES; n++)
      send_command(CMD_MOVE, box_beat(n, n, n, n, 64, 64, 64));
    for (int n = 0; n < 6; n++)
      send_command(CMD_TICK, '0);
    drain();
  endtask

  initial begin
    rst            <= 1'b1;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= '0;
    s_axis_tuser   <= CMD_TICK;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_until     = 0;
    boxes_held     = 0;
    for (int p = 0; p < NUM_PAIRS; p++)
      pair_touching[p] = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random(70, 0, 0);
    test_random(70, 74, 0);
    test_random(70, 0, 74);
    test_random(70, 25, 25);
    test_backpressure();

    if (mismatches == 0)
      $display("aabb_pair_collision_events_core regression: pass");
    else
      $display("aabb_pair_collision_events_core regression: fail");
    $finish;
  end

endmodule
